[design/point_light_radius_search_macros.svh]
// ----------------------------------------------------------------------------
// Point light radius search: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_RADIUS_SEARCH_MACROS_SVH
`define POINT_LIGHT_RADIUS_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/plrs_pkg.sv]
// ----------------------------------------------------------------------------
// Point light radius search package
// Request types, probe table and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package plrs_pkg;

    localparam int unsigned IN_W             = 24;
    localparam int unsigned THR_W            = 16;
    localparam int unsigned RADIUS_W         = 11;
    localparam int unsigned LHS_W            = THR_W + IN_W;
    localparam int unsigned THR_RESET        = 255;
    localparam int unsigned SEARCH_LIMIT_DEF = 1024;

    localparam int unsigned NUM_PROBES = 7;
    localparam int unsigned PIDX_W     = 3;
    localparam int unsigned PROBE_D_W  = 10;

    typedef struct packed {
        logic        [IN_W-1:0] atten_const;
        logic        [IN_W-1:0] atten_lin;
        logic        [IN_W-1:0] atten_quad;
        logic signed [IN_W-1:0] light_power;
    } t_in_req;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                is_infinite;
    } t_out_req;

    // One bracketing probe: distance, which side counts as a hit, and where
    // the linear search starts on a hit (or that the result is infinite).
    typedef struct packed {
        logic [PROBE_D_W-1:0] distance;
        logic                 hit_above;
        logic                 start_inf;
        logic [PROBE_D_W-1:0] start;
    } t_probe;

    localparam t_probe PROBES [NUM_PROBES] = '{
        '{distance: 10'd1000, hit_above: 1'b1, start_inf: 1'b1, start: 10'd0},
        '{distance: 10'd20,   hit_above: 1'b0, start_inf: 1'b0, start: 10'd0},
        '{distance: 10'd750,  hit_above: 1'b1, start_inf: 1'b0, start: 10'd750},
        '{distance: 10'd50,   hit_above: 1'b0, start_inf: 1'b0, start: 10'd21},
        '{distance: 10'd100,  hit_above: 1'b0, start_inf: 1'b0, start: 10'd51},
        '{distance: 10'd500,  hit_above: 1'b1, start_inf: 1'b0, start: 10'd500},
        '{distance: 10'd250,  hit_above: 1'b1, start_inf: 1'b0, start: 10'd250}
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_LHS,
        S_MUL_LIN,
        S_MUL_SQ,
        S_PROBE,
        S_DELTA,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[design/point_light_radius_search.sv]
// ----------------------------------------------------------------------------
// Point light radius search
// Finds the smallest whole distance at which a point light drops below the
// brightness cutoff, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A request runs through the intensity product, a multiply, multiply and
// compare pass per probe (up to 7 probes), the set-up of the start point,
// a linear scan that tests one distance per step up to SEARCH_LIMIT
// (default 1024), and the hand-off of the result into the output register,
// which waits while a result held there is stalled. The request port opens
// again as the result enters the output register. The scan loop, which
// advances the attenuation by forward differences, dominates the worst case.
// A new request is taken only once the previous one has moved into the output
// register; a result waiting there does not hold off the next request.
`default_nettype none
`include "point_light_radius_search_macros.svh"

module point_light_radius_search
    import plrs_pkg::*;
#(
    parameter int unsigned SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_req          i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_req              o_out
);

    localparam int unsigned DW  = $clog2(SEARCH_LIMIT + 1);
    localparam int unsigned MA  = IN_W + DW;
    localparam int unsigned MB  = (DW + 1 > THR_W) ? DW + 1 : THR_W;
    localparam int unsigned PW  = MA + MB;
    localparam int unsigned AW  = IN_W + 2 * DW;
    localparam int unsigned DLW = IN_W + 1 + DW;

    t_state                r_state, n_state;
    logic [THR_W-1:0]      r_thr;
    t_in_req               r_req, n_req;
    logic [LHS_W-1:0]      r_lhs, n_lhs;
    logic [AW-1:0]         r_acc, n_acc;
    logic [DLW-1:0]        r_delta, n_delta;
    logic [DW-1:0]         r_d, n_d;
    logic [PIDX_W-1:0]     r_pidx, n_pidx;
    logic                  r_start_eval, n_start_eval;
    t_out_req              r_res, n_res;
    t_out_req              r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [MA-1:0]         mul_a;
    logic [MB-1:0]         mul_b;
    logic [PW-1:0]         mul_p;
    logic [IN_W-1:0]       power_bits;
    logic [IN_W-1:0]       mag;
    logic [AW-1:0]         lhs_ext;
    logic                  lum_above, lum_below;
    t_probe                probe;
    logic                  probe_hit, last_probe, at_limit;
    logic                  in_accept, out_free;

    // ------------------------------------------------------------------
    // Shared multiplier and compare
    // ------------------------------------------------------------------
    assign power_bits = r_req.light_power;
    assign mag        = power_bits[IN_W-1] ? (~power_bits + IN_W'(1)) : power_bits;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LHS: begin
                mul_a = MA'(mag);
                mul_b = MB'(r_thr);
            end
            S_MUL_LIN: begin
                mul_a = MA'(r_req.atten_quad);
                mul_b = MB'(r_d);
            end
            S_MUL_SQ: begin
                mul_a = r_acc[MA-1:0];
                mul_b = MB'(r_d);
            end
            S_DELTA: begin
                mul_a = MA'(r_req.atten_quad);
                mul_b = MB'({r_d, 1'b1});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign lhs_ext    = AW'(r_lhs);
    assign lum_above  = lhs_ext > r_acc;
    assign lum_below  = lhs_ext < r_acc;
    assign probe      = PROBES[r_pidx];
    assign probe_hit  = probe.hit_above ? lum_above : lum_below;
    assign last_probe = (r_pidx == PIDX_W'(NUM_PROBES - 1));
    assign at_limit   = (r_d == DW'(SEARCH_LIMIT));

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LHS;
                end
            end
            S_LHS:     n_state = S_MUL_LIN;
            S_MUL_LIN: n_state = S_MUL_SQ;
            S_MUL_SQ: begin
                n_state = r_start_eval ? S_DELTA : S_PROBE;
            end
            S_PROBE: begin
                if (probe_hit && probe.start_inf) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_LIN;
                end
            end
            S_DELTA: n_state = S_SCAN;
            S_SCAN: begin
                if (lum_below || at_limit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_req        = r_req;
        n_lhs        = r_lhs;
        n_acc        = r_acc;
        n_delta      = r_delta;
        n_d          = r_d;
        n_pidx       = r_pidx;
        n_start_eval = r_start_eval;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req = i_in;
                end
            end
            S_LHS: begin
                n_lhs        = mul_p[LHS_W-1:0];
                n_pidx       = '0;
                n_d          = DW'(PROBES[0].distance);
                n_start_eval = 1'b0;
            end
            S_MUL_LIN: begin
                n_acc = mul_p[AW-1:0] + AW'(r_req.atten_lin);
            end
            S_MUL_SQ: begin
                n_acc = mul_p[AW-1:0] + AW'(r_req.atten_const);
            end
            S_PROBE: begin
                if (probe_hit) begin
                    if (probe.start_inf) begin
                        n_res.radius      = '0;
                        n_res.is_infinite = 1'b1;
                    end else begin
                        n_d          = DW'(probe.start);
                        n_start_eval = 1'b1;
                    end
                end else if (last_probe) begin
                    n_d          = '0;
                    n_start_eval = 1'b1;
                end else begin
                    n_pidx = r_pidx + PIDX_W'(1);
                    n_d    = DW'(PROBES[r_pidx + PIDX_W'(1)].distance);
                end
            end
            S_DELTA: begin
                n_delta = mul_p[DLW-1:0] + DLW'(r_req.atten_lin);
            end
            S_SCAN: begin
                if (lum_below) begin
                    n_res.radius      = RADIUS_W'(r_d);
                    n_res.is_infinite = 1'b0;
                end else if (at_limit) begin
                    n_res.radius      = '0;
                    n_res.is_infinite = 1'b1;
                end else begin
                    // A(d+1) = A(d) + delta(d); delta(d+1) = delta(d) + 2q.
                    n_acc   = r_acc + AW'(r_delta);
                    n_delta = r_delta + DLW'({r_req.atten_quad, 1'b0});
                    n_d     = r_d + DW'(1);
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_state == S_DONE && out_free) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= THR_W'(THR_RESET);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_lhs        <= n_lhs;
        r_acc        <= n_acc;
        r_delta      <= n_delta;
        r_d          <= n_d;
        r_pidx       <= n_pidx;
        r_start_eval <= n_start_eval;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PLRS_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN, r_d <= DW'(SEARCH_LIMIT),
        "scan distance passed the search limit")
    `PLRS_ASSERT_NEXT(a_scan_monotonic, r_state == S_SCAN && !lum_below && !at_limit,
        r_acc >= $past(r_acc), "attenuation decreased during the scan")
    `PLRS_ASSERT_NEXT(a_accept_starts, in_accept, r_state == S_LHS,
        "accepted request did not start the sequencer")
    `PLRS_ASSERT_NOW(a_inf_radius_zero, o_out_valid && o_out.is_infinite, o_out.radius == '0,
        "infinite result carries a nonzero radius")

endmodule

`default_nettype wire
